// File: hw/rtl/kav_pkg.sv
`default_nettype none
package kav_pkg;

  localparam int ADDR_W = 6;
  localparam int PC_W   = 7;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [3:0] {
    OP_LD,
    OP_ADD,
    OP_SUB,
    OP_HALF,
    OP_MUL,
    OP_DIV,
    OP_DT,
    OP_OUT,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    SRC_ALT,
    SRC_ZERO,
    SRC_ONE,
    SRC_BIG,
    SRC_DMP,
    SRC_QA,
    SRC_QB,
    SRC_MV
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT,
    ST_PUB
  } st_e;

  typedef struct packed {
    op_e   op;
    src_e  src;
    addr_t dst;
    addr_t a;
    addr_t b;
  } uop_t;

  localparam logic [1:0] CFG_MEAS = 2'd0;
  localparam logic [1:0] CFG_ACC  = 2'd1;
  localparam logic [1:0] CFG_BIAS = 2'd2;
  localparam logic [1:0] CFG_DMP  = 2'd3;

  // register file map
  localparam addr_t A_ALT  = 6'd0;
  localparam addr_t A_SPD  = 6'd1;
  localparam addr_t A_BIAS = 6'd2;
  localparam addr_t A_P0   = 6'd3;
  localparam addr_t A_P1   = 6'd4;
  localparam addr_t A_P2   = 6'd5;
  localparam addr_t A_P3   = 6'd6;
  localparam addr_t A_P4   = 6'd7;
  localparam addr_t A_P5   = 6'd8;
  localparam addr_t A_P6   = 6'd9;
  localparam addr_t A_P7   = 6'd10;
  localparam addr_t A_P8   = 6'd11;
  localparam addr_t A_SM   = 6'd12;
  localparam addr_t A_DT   = 6'd13;
  localparam addr_t A_H2   = 6'd14;
  localparam addr_t A_H3   = 6'd15;
  localparam addr_t A_Q4   = 6'd16;
  localparam addr_t A_DSQ  = 6'd17;
  localparam addr_t A_T0   = 6'd18;
  localparam addr_t A_T1   = 6'd19;
  localparam addr_t A_T2   = 6'd20;
  localparam addr_t A_T3   = 6'd21;
  localparam addr_t A_T4   = 6'd22;
  localparam addr_t A_T5   = 6'd23;
  localparam addr_t A_X    = 6'd24;
  localparam addr_t A_DMP  = 6'd25;
  localparam addr_t A_QA   = 6'd26;
  localparam addr_t A_QB   = 6'd27;
  localparam addr_t A_MV   = 6'd28;
  localparam addr_t A_TMP  = 6'd29;
  localparam addr_t A_ZR   = 6'd30;
  localparam addr_t A_S    = 6'd31;
  localparam addr_t A_KZ   = 6'd32;
  localparam addr_t A_KV   = 6'd33;
  localparam addr_t A_KA   = 6'd34;
  localparam addr_t A_INN  = 6'd35;

  // output slot select carried in the dst field
  localparam addr_t O_ALT  = 6'd0;
  localparam addr_t O_SPD  = 6'd1;
  localparam addr_t O_BIAS = 6'd2;
  localparam addr_t O_SM   = 6'd3;

  localparam logic [PC_W-1:0] PC_INIT = 7'd0;
  localparam logic [PC_W-1:0] PC_UPD  = 7'd18;

  function automatic uop_t mk(op_e op, addr_t dst, addr_t a, addr_t b);
    uop_t u;
    u.op  = op;
    u.src = SRC_ZERO;
    u.dst = dst;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  function automatic uop_t mk_ld(addr_t dst, src_e src);
    uop_t u;
    u.op  = OP_LD;
    u.src = src;
    u.dst = dst;
    u.a   = A_ZR;
    u.b   = A_ZR;
    return u;
  endfunction

  function automatic uop_t kav_rom(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // initialise
      7'd0:   u = mk_ld(A_ALT, SRC_ALT);
      7'd1:   u = mk_ld(A_SM, SRC_ALT);
      7'd2:   u = mk_ld(A_SPD, SRC_ZERO);
      7'd3:   u = mk_ld(A_BIAS, SRC_ZERO);
      7'd4:   u = mk_ld(A_P0, SRC_ONE);
      7'd5:   u = mk_ld(A_P1, SRC_ZERO);
      7'd6:   u = mk_ld(A_P2, SRC_ZERO);
      7'd7:   u = mk_ld(A_P3, SRC_ZERO);
      7'd8:   u = mk_ld(A_P4, SRC_ONE);
      7'd9:   u = mk_ld(A_P5, SRC_ZERO);
      7'd10:  u = mk_ld(A_P6, SRC_ZERO);
      7'd11:  u = mk_ld(A_P7, SRC_ZERO);
      7'd12:  u = mk_ld(A_P8, SRC_BIG);
      7'd13:  u = mk(OP_OUT, O_ALT, A_ALT, A_ZR);
      7'd14:  u = mk(OP_OUT, O_SPD, A_SPD, A_ZR);
      7'd15:  u = mk(OP_OUT, O_BIAS, A_BIAS, A_ZR);
      7'd16:  u = mk(OP_OUT, O_SM, A_SM, A_ZR);
      7'd17:  u = mk(OP_DONE, A_ZR, A_ZR, A_ZR);
      // update
      7'd18:  u = mk_ld(A_ZR, SRC_ZERO);
      7'd19:  u = mk_ld(A_X, SRC_ALT);
      7'd20:  u = mk_ld(A_DMP, SRC_DMP);
      7'd21:  u = mk_ld(A_QA, SRC_QA);
      7'd22:  u = mk_ld(A_QB, SRC_QB);
      7'd23:  u = mk_ld(A_MV, SRC_MV);
      7'd24:  u = mk(OP_SUB, A_TMP, A_X, A_SM);
      7'd25:  u = mk(OP_MUL, A_TMP, A_TMP, A_DMP);
      7'd26:  u = mk(OP_ADD, A_SM, A_SM, A_TMP);
      7'd27:  u = mk(OP_DT, A_DT, A_ZR, A_ZR);
      7'd28:  u = mk(OP_MUL, A_DSQ, A_DT, A_DT);
      7'd29:  u = mk(OP_HALF, A_H2, A_DSQ, A_ZR);
      7'd30:  u = mk(OP_MUL, A_H3, A_H2, A_DT);
      7'd31:  u = mk(OP_MUL, A_Q4, A_H2, A_H2);
      7'd32:  u = mk(OP_SUB, A_TMP, A_ZR, A_BIAS);
      7'd33:  u = mk(OP_MUL, A_TMP, A_TMP, A_DT);
      7'd34:  u = mk(OP_ADD, A_SPD, A_SPD, A_TMP);
      7'd35:  u = mk(OP_MUL, A_TMP, A_SPD, A_DT);
      7'd36:  u = mk(OP_ADD, A_ALT, A_ALT, A_TMP);
      7'd37:  u = mk(OP_MUL, A_TMP, A_DT, A_P3);
      7'd38:  u = mk(OP_ADD, A_T0, A_P0, A_TMP);
      7'd39:  u = mk(OP_MUL, A_TMP, A_H2, A_P6);
      7'd40:  u = mk(OP_SUB, A_T0, A_T0, A_TMP);
      7'd41:  u = mk(OP_MUL, A_TMP, A_DT, A_P4);
      7'd42:  u = mk(OP_ADD, A_T1, A_P1, A_TMP);
      7'd43:  u = mk(OP_MUL, A_TMP, A_H2, A_P7);
      7'd44:  u = mk(OP_SUB, A_T1, A_T1, A_TMP);
      7'd45:  u = mk(OP_MUL, A_TMP, A_DT, A_P5);
      7'd46:  u = mk(OP_ADD, A_T2, A_P2, A_TMP);
      7'd47:  u = mk(OP_MUL, A_TMP, A_H2, A_P8);
      7'd48:  u = mk(OP_SUB, A_T2, A_T2, A_TMP);
      7'd49:  u = mk(OP_MUL, A_TMP, A_DT, A_P6);
      7'd50:  u = mk(OP_SUB, A_T3, A_P3, A_TMP);
      7'd51:  u = mk(OP_MUL, A_TMP, A_DT, A_P7);
      7'd52:  u = mk(OP_SUB, A_T4, A_P4, A_TMP);
      7'd53:  u = mk(OP_MUL, A_TMP, A_DT, A_P8);
      7'd54:  u = mk(OP_SUB, A_T5, A_P5, A_TMP);
      7'd55:  u = mk(OP_MUL, A_TMP, A_DT, A_T1);
      7'd56:  u = mk(OP_ADD, A_P0, A_T0, A_TMP);
      7'd57:  u = mk(OP_MUL, A_TMP, A_H2, A_T2);
      7'd58:  u = mk(OP_SUB, A_P0, A_P0, A_TMP);
      7'd59:  u = mk(OP_MUL, A_TMP, A_DT, A_T2);
      7'd60:  u = mk(OP_SUB, A_P1, A_T1, A_TMP);
      7'd61:  u = mk(OP_ADD, A_P2, A_T2, A_ZR);
      7'd62:  u = mk(OP_MUL, A_TMP, A_DT, A_T4);
      7'd63:  u = mk(OP_ADD, A_P3, A_T3, A_TMP);
      7'd64:  u = mk(OP_MUL, A_TMP, A_H2, A_T5);
      7'd65:  u = mk(OP_SUB, A_P3, A_P3, A_TMP);
      7'd66:  u = mk(OP_MUL, A_TMP, A_DT, A_T5);
      7'd67:  u = mk(OP_SUB, A_P4, A_T4, A_TMP);
      7'd68:  u = mk(OP_ADD, A_P5, A_T5, A_ZR);
      7'd69:  u = mk(OP_MUL, A_TMP, A_DT, A_P7);
      7'd70:  u = mk(OP_ADD, A_P6, A_P6, A_TMP);
      7'd71:  u = mk(OP_MUL, A_TMP, A_H2, A_P8);
      7'd72:  u = mk(OP_SUB, A_P6, A_P6, A_TMP);
      7'd73:  u = mk(OP_MUL, A_TMP, A_DT, A_P8);
      7'd74:  u = mk(OP_SUB, A_P7, A_P7, A_TMP);
      7'd75:  u = mk(OP_MUL, A_TMP, A_Q4, A_QA);
      7'd76:  u = mk(OP_ADD, A_P0, A_P0, A_TMP);
      7'd77:  u = mk(OP_MUL, A_TMP, A_H3, A_QA);
      7'd78:  u = mk(OP_ADD, A_P1, A_P1, A_TMP);
      7'd79:  u = mk(OP_ADD, A_P3, A_P3, A_TMP);
      7'd80:  u = mk(OP_MUL, A_TMP, A_DSQ, A_QA);
      7'd81:  u = mk(OP_ADD, A_P4, A_P4, A_TMP);
      7'd82:  u = mk(OP_ADD, A_P8, A_P8, A_QB);
      7'd83:  u = mk(OP_SUB, A_INN, A_X, A_ALT);
      7'd84:  u = mk(OP_ADD, A_S, A_P0, A_MV);
      7'd85:  u = mk(OP_DIV, A_KZ, A_P0, A_S);
      7'd86:  u = mk(OP_DIV, A_KV, A_P3, A_S);
      7'd87:  u = mk(OP_DIV, A_KA, A_P6, A_S);
      7'd88:  u = mk(OP_MUL, A_TMP, A_KZ, A_INN);
      7'd89:  u = mk(OP_ADD, A_ALT, A_ALT, A_TMP);
      7'd90:  u = mk(OP_MUL, A_TMP, A_KV, A_INN);
      7'd91:  u = mk(OP_ADD, A_SPD, A_SPD, A_TMP);
      7'd92:  u = mk(OP_MUL, A_TMP, A_KA, A_INN);
      7'd93:  u = mk(OP_ADD, A_BIAS, A_BIAS, A_TMP);
      7'd94:  u = mk(OP_MUL, A_TMP, A_KA, A_P0);
      7'd95:  u = mk(OP_SUB, A_P6, A_P6, A_TMP);
      7'd96:  u = mk(OP_MUL, A_TMP, A_KA, A_P1);
      7'd97:  u = mk(OP_SUB, A_P7, A_P7, A_TMP);
      7'd98:  u = mk(OP_MUL, A_TMP, A_KA, A_P2);
      7'd99:  u = mk(OP_SUB, A_P8, A_P8, A_TMP);
      7'd100: u = mk(OP_MUL, A_TMP, A_KV, A_P0);
      7'd101: u = mk(OP_SUB, A_P3, A_P3, A_TMP);
      7'd102: u = mk(OP_MUL, A_TMP, A_KV, A_P1);
      7'd103: u = mk(OP_SUB, A_P4, A_P4, A_TMP);
      7'd104: u = mk(OP_MUL, A_TMP, A_KV, A_P2);
      7'd105: u = mk(OP_SUB, A_P5, A_P5, A_TMP);
      7'd106: u = mk(OP_MUL, A_TMP, A_KZ, A_P0);
      7'd107: u = mk(OP_SUB, A_P0, A_P0, A_TMP);
      7'd108: u = mk(OP_MUL, A_TMP, A_KZ, A_P1);
      7'd109: u = mk(OP_SUB, A_P1, A_P1, A_TMP);
      7'd110: u = mk(OP_MUL, A_TMP, A_KZ, A_P2);
      7'd111: u = mk(OP_SUB, A_P2, A_P2, A_TMP);
      7'd112: u = mk(OP_OUT, O_ALT, A_ALT, A_ZR);
      7'd113: u = mk(OP_OUT, O_SPD, A_SPD, A_ZR);
      7'd114: u = mk(OP_OUT, O_BIAS, A_BIAS, A_ZR);
      7'd115: u = mk(OP_OUT, O_SM, A_SM, A_ZR);
      default: u = mk(OP_DONE, A_ZR, A_ZR, A_ZR);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/kav_regfile.sv
`default_nettype none
module kav_regfile (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire kav_pkg::addr_t       waddr,
  input  wire logic [63:0]          wdata,
  input  wire kav_pkg::addr_t       raddr_a,
  input  wire kav_pkg::addr_t       raddr_b,
  output logic [63:0]               rdata_a,
  output logic [63:0]               rdata_b
);
  import kav_pkg::*;

  logic [63:0] mem [1<<ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// File: hw/rtl/kav_mul.sv
`default_nettype none
module kav_mul #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      res
);
  import kav_pkg::*;

  localparam logic [127:0] HALF = 128'(1) << (FRAC_BITS - 1);
  localparam logic [63:0]  SMAX = {1'b0, {63{1'b1}}};

  logic         busy_r;
  logic [2:0]   cnt_r;
  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  logic [63:0]  pp_r;
  logic [1:0]   pk_r;
  logic [127:0] acc_r;
  logic [63:0]  res_r;
  logic         done_r;

  logic [31:0]  pa, pb;
  logic [127:0] pp_sh;
  logic [127:0] rnd;
  logic [127:0] q;
  logic [63:0]  qmag;

  always_comb begin
    pa = cnt_r[0] ? ma_r[63:32] : ma_r[31:0];
    pb = cnt_r[1] ? mb_r[63:32] : mb_r[31:0];
    case (pk_r)
      2'd0:    pp_sh = {64'b0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'b0};
      default: pp_sh = {32'b0, pp_r, 32'b0};
    endcase
    rnd  = acc_r + HALF;
    q    = rnd >> FRAC_BITS;
    qmag = (|q[127:63]) ? SMAX : q[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[63] ^ b[63];
      ma_r  <= a[63] ? 64'(-a) : a;
      mb_r  <= b[63] ? 64'(-b) : b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        pp_r <= pa * pb;
        pk_r <= cnt_r[1:0];
      end
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
        acc_r <= acc_r + pp_sh;
      end
      if (cnt_r == 3'd5) begin
        res_r <= neg_r ? 64'(-qmag) : qmag;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/kav_div.sv
`default_nettype none
module kav_div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] num,
  input  wire logic [63:0]  den,
  input  wire logic         neg,
  output logic              done,
  output logic [63:0]       res
);
  import kav_pkg::*;

  localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};

  logic         busy_r;
  logic [6:0]   i_r;
  logic [127:0] num_r;
  logic [63:0]  den_r;
  logic [63:0]  rem_r;
  logic [62:0]  q_r;
  logic         over_r;
  logic         neg_r;
  logic [63:0]  res_r;
  logic         done_r;

  logic [64:0]  r2;
  logic         ge;
  logic [64:0]  diff;
  logic [62:0]  q_fin;
  logic [63:0]  qmag;

  always_comb begin
    r2    = {rem_r, num_r[127]};
    ge    = r2 >= {1'b0, den_r};
    diff  = r2 - {1'b0, den_r};
    q_fin = {q_r[61:0], ge};
    qmag  = over_r ? SMAX : {1'b0, q_fin};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == 7'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i_r    <= 7'd127;
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
      neg_r  <= neg;
    end else if (busy_r) begin
      i_r   <= i_r - 7'd1;
      num_r <= {num_r[126:0], 1'b0};
      rem_r <= ge ? diff[63:0] : r2[63:0];
      if (i_r >= 7'd63) begin
        over_r <= over_r | ge;
      end else begin
        q_r <= q_fin;
      end
      if (i_r == 7'd0) begin
        res_r <= neg_r ? 64'(-qmag) : qmag;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/kalman_altitude_vario.sv
`default_nettype none
// an update word skips the three divider runs when the innovation variance is not positive;
// both word kinds publish their result through out_valid
// flow: one word at a time, next word can be taken in the cycle that out_valid rises; the
// 128-step shared divider (three runs) and the four-partial-product shared multiplier
// (39 runs) over the one register file set the pace; a held result stalls the publish step
// reset: a boot pass loads the initial state, in_ready low meanwhile
module kalman_altitude_vario #(
  parameter int STATE_FRAC_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_measured_altitude,
  input  wire logic [15:0] in_elapsed_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_filtered_altitude,
  output logic [31:0]      out_vertical_speed,
  output logic [31:0]      out_accel_bias,
  output logic [31:0]      out_damped_altitude,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import kav_pkg::*;

  localparam int          F    = STATE_FRAC_BITS;
  localparam int          SH   = F - 16;
  localparam logic [64:0] RND  = (SH == 0) ? '0 : (65'(1) << ((SH == 0) ? 0 : SH - 1));
  localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SMIN = {1'b1, {63{1'b0}}};
  // dt = ms * (2^F div 1000) + (ms * (2^F mod 1000) + 500) div 1000
  localparam logic [31:0] DT_Q = 32'((128'(1) << F) / 128'd1000);
  localparam logic [9:0]  DT_R = 10'((128'(1) << F) % 128'd1000);
  localparam logic [26:0] DT_M = 27'd68719477;

  st_e               state_r, state_nxt;
  logic [PC_W-1:0]   pc_r;
  logic              boot_r;
  logic [31:0]       alt_r;
  logic [15:0]       ms_r;
  logic [31:0]       meas_var_r, acc_var_r, bias_var_r;
  logic [16:0]       dmp_r;
  logic [31:0]       stage_r [4];
  logic              out_valid_r;
  logic [31:0]       out_alt_r, out_spd_r, out_bias_r, out_sm_r;
  logic [25:0]       dt_y_r;
  logic [63:0]       dt_base_r;
  logic [16:0]       dt_frac_r;
  logic [63:0]       dt_res_r;
  logic [2:0]        dt_stage_r;

  uop_t              uop;
  logic [63:0]       a_q, b_q;
  logic              we;
  logic [63:0]       wdata;
  logic              pc_inc, stage_we, publish;
  logic              mul_start, div_start, dt_start;
  logic              mul_done, div_done, dt_done;
  logic [63:0]       mul_res, div_res;
  logic [127:0]      div_num;
  logic [63:0]       div_den;
  logic              div_neg;
  logic [52:0]       dt_prod;
  logic [63:0]       ld_val;
  logic [64:0]       sum65, dif65;
  logic [63:0]       add_sat, sub_sat, half_v;
  logic [64:0]       cv65;
  logic [63:0]       cv_sat, cv_sh;
  logic [31:0]       cv_port;
  logic [63:0]       mag_a;
  logic              b_pos;
  logic              unit_done;
  logic [63:0]       unit_res;
  logic              accept, out_free;

  assign uop      = kav_rom(pc_r);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign dt_done  = dt_stage_r[2];

  kav_regfile u_rf (
    .clk     (clk),
    .we      (we),
    .waddr   (uop.dst),
    .wdata   (wdata),
    .raddr_a (uop.a),
    .raddr_b (uop.b),
    .rdata_a (a_q),
    .rdata_b (b_q)
  );

  kav_mul #(.FRAC_BITS(F)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (a_q),
    .b     (b_q),
    .done  (mul_done),
    .res   (mul_res)
  );

  kav_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .done  (div_done),
    .res   (div_res)
  );

  // datapath
  always_comb begin
    case (uop.src)
      SRC_ALT:  ld_val = {{32{alt_r[31]}}, alt_r} << SH;
      SRC_ONE:  ld_val = 64'(1) << F;
      SRC_BIG:  ld_val = 64'(100000) << F;
      SRC_DMP:  ld_val = {47'b0, dmp_r} << SH;
      SRC_QA:   ld_val = {32'b0, acc_var_r} << SH;
      SRC_QB:   ld_val = {32'b0, bias_var_r} << SH;
      SRC_MV:   ld_val = {32'b0, meas_var_r} << SH;
      default:  ld_val = '0;
    endcase

    sum65 = {a_q[63], a_q} + {b_q[63], b_q};
    dif65 = {a_q[63], a_q} - {b_q[63], b_q};
    if (sum65[64] != sum65[63]) add_sat = sum65[64] ? SMIN : SMAX;
    else                        add_sat = sum65[63:0];
    if (dif65[64] != dif65[63]) sub_sat = dif65[64] ? SMIN : SMAX;
    else                        sub_sat = dif65[63:0];
    half_v = 64'($signed(a_q + {63'b0, a_q[63]}) >>> 1);

    cv65 = {a_q[63], a_q} + RND;
    if (cv65[64] != cv65[63]) cv_sat = cv65[64] ? SMIN : SMAX;
    else                      cv_sat = cv65[63:0];
    cv_sh = 64'($signed(cv_sat) >>> SH);
    if (cv_sh[63:31] == {33{cv_sh[63]}}) cv_port = cv_sh[31:0];
    else                                 cv_port = cv_sh[63] ? 32'h8000_0000 : 32'h7fff_ffff;

    mag_a = a_q[63] ? 64'(-a_q) : a_q;
    b_pos = !b_q[63] && (|b_q);
    div_num = {64'b0, mag_a} << F;
    div_den = b_q;
    div_neg = a_q[63];

    dt_prod = {27'b0, dt_y_r} * {26'b0, DT_M};

    case (uop.op)
      OP_MUL: begin
        unit_done = mul_done;
        unit_res  = mul_res;
      end
      OP_DT: begin
        unit_done = dt_done;
        unit_res  = dt_res_r;
      end
      default: begin
        unit_done = div_done;
        unit_res  = div_res;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (uop.op)
          OP_MUL, OP_DT: state_nxt = ST_WAIT;
          OP_DIV:        state_nxt = b_pos ? ST_WAIT : ST_FETCH;
          OP_DONE:       state_nxt = boot_r ? ST_IDLE : ST_PUB;
          default:       state_nxt = ST_FETCH;
        endcase
      end
      ST_WAIT:  if (unit_done) state_nxt = ST_FETCH;
      ST_PUB:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    we        = 1'b0;
    wdata     = '0;
    pc_inc    = 1'b0;
    stage_we  = 1'b0;
    publish   = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    dt_start  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: begin
        case (uop.op)
          OP_LD: begin
            we = 1'b1; wdata = ld_val; pc_inc = 1'b1;
          end
          OP_ADD: begin
            we = 1'b1; wdata = add_sat; pc_inc = 1'b1;
          end
          OP_SUB: begin
            we = 1'b1; wdata = sub_sat; pc_inc = 1'b1;
          end
          OP_HALF: begin
            we = 1'b1; wdata = half_v; pc_inc = 1'b1;
          end
          OP_MUL: mul_start = 1'b1;
          OP_DT:  dt_start = 1'b1;
          OP_DIV: begin
            if (b_pos) begin
              div_start = 1'b1;
            end else begin
              we = 1'b1; wdata = '0; pc_inc = 1'b1;
            end
          end
          OP_OUT: begin
            stage_we = 1'b1; pc_inc = 1'b1;
          end
          default: ;
        endcase
      end
      ST_WAIT: begin
        if (unit_done) begin
          we = 1'b1; wdata = unit_res; pc_inc = 1'b1;
        end
      end
      ST_PUB: publish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      pc_r        <= PC_INIT;
      boot_r      <= 1'b1;
      alt_r       <= '0;
      out_valid_r <= 1'b0;
      meas_var_r  <= 32'd26214400;
      acc_var_r   <= 32'd65536000;
      bias_var_r  <= 32'd65536;
      dmp_r       <= 17'd3277;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        alt_r <= in_measured_altitude;
        ms_r  <= in_elapsed_ms;
        pc_r  <= in_mode ? PC_INIT : PC_UPD;
      end else if (pc_inc) begin
        pc_r <= pc_r + 7'd1;
      end
      if (state_r == ST_EXEC && uop.op == OP_DONE) boot_r <= 1'b0;
      if (publish)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MEAS: meas_var_r <= cfg_data;
          CFG_ACC:  acc_var_r  <= cfg_data;
          CFG_BIAS: bias_var_r <= cfg_data;
          CFG_DMP:  dmp_r      <= cfg_data[16:0];
          default:  ;
        endcase
      end
    end
  end

  // time step unit, pipelined through dt_stage_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_stage_r <= '0;
    end else begin
      dt_stage_r <= {dt_stage_r[1:0], dt_start};
    end
  end

  always_ff @(posedge clk) begin
    if (dt_start) begin
      dt_y_r    <= {10'b0, ms_r} * {16'b0, DT_R} + 26'd500;
      dt_base_r <= {48'b0, ms_r} * {32'b0, DT_Q};
    end
    if (dt_stage_r[0]) dt_frac_r <= dt_prod[52:36];
    if (dt_stage_r[1]) dt_res_r <= dt_base_r + {47'b0, dt_frac_r};
  end

  always_ff @(posedge clk) begin
    if (stage_we) stage_r[uop.dst[1:0]] <= cv_port;
    if (publish) begin
      out_alt_r  <= stage_r[0];
      out_spd_r  <= stage_r[1];
      out_bias_r <= stage_r[2];
      out_sm_r   <= stage_r[3];
    end
  end

  assign cfg_ready             = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_filtered_altitude = out_alt_r;
  assign out_vertical_speed    = out_spd_r;
  assign out_accel_bias        = out_bias_r;
  assign out_damped_altitude   = out_sm_r;

endmodule
`default_nettype wire

// File: bench/tb_kalman_altitude_vario.sv
`timescale 1ns / 100ps
module tb_kalman_altitude_vario;
  import kav_pkg::*;

  localparam int  FRAC        = 32;
  localparam bit  MODE_UPDATE = 1'b0;
  localparam bit  MODE_INIT   = 1'b1;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam longint SMAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SMIN     = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [31:0] alt;
    logic [31:0] spd;
    logic [31:0] bias;
    logic [31:0] damp;
  } vario_word_t;

  class vario_scoreboard;
    longint      alt_est, spd_est, bias_est, smooth;
    longint      cov[9];
    logic [31:0] meas_var, acc_var, bias_var;
    logic [16:0] damping;
    vario_word_t expected_q[$];
    int          errors;
    int          checked;
    int          init_words;
    int          update_words;

    function new();
      restart(0);
      smooth   = 0;
      meas_var = 32'd26214400;
      acc_var  = 32'd65536000;
      bias_var = 32'd65536;
      damping  = 17'd3277;
      errors   = 0;
      checked  = 0;
    endfunction

    function void restart(longint a);
      alt_est  = a;
      spd_est  = 0;
      bias_est = 0;
      foreach (cov[i]) cov[i] = 0;
      cov[0] = 64'sd1 <<< FRAC;
      cov[4] = 64'sd1 <<< FRAC;
      cov[8] = (64'sd1 <<< FRAC) * 100000;
      smooth = a;
    endfunction

    function longint add_sat(longint a, longint b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
    endfunction

    function longint sub_sat(longint a, longint b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
    endfunction

    function logic [63:0] magnitude(longint a);
      return a[63] ? (~a + 64'd1) : a;
    endfunction

    function longint mul_fx(longint a, longint b);
      logic [127:0] p;
      logic [63:0]  m;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
      m = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
      return (a[63] ^ b[63]) ? -longint'(m) : longint'(m);
    endfunction

    function longint div_fx(longint a, longint s);
      logic [127:0] q;
      logic [63:0]  m;
      q = ({64'd0, magnitude(a)} << FRAC) / {64'd0, s};
      m = (q > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
      return a[63] ? -longint'(m) : longint'(m);
    endfunction

    function logic [31:0] to_q16(longint x);
      x = add_sat(x, 64'sd1 <<< (FRAC - 17));
      x = x >>> (FRAC - 16);
      if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (x < -64'sh8000_0000) return 32'h8000_0000;
      return x[31:0];
    endfunction

    function void filter_update(longint a, logic [15:0] ms);
      longint dt, h2, h3, q4, dsq, qa, innov, s, kz, kv, ka, pzz, pzv, pza;
      longint t[9];
      logic [63:0] udt;
      smooth = add_sat(smooth, mul_fx(sub_sat(a, smooth),
                                      longint'({47'd0, damping}) <<< (FRAC - 16)));
      udt = (({48'd0, ms} << FRAC) + 64'd500) / 64'd1000;
      dt  = udt;
      h2  = mul_fx(dt, dt) / 2;
      h3  = mul_fx(h2, dt);
      q4  = mul_fx(h2, h2);
      dsq = mul_fx(dt, dt);

      spd_est = add_sat(spd_est, mul_fx(sub_sat(0, bias_est), dt));
      alt_est = add_sat(alt_est, mul_fx(spd_est, dt));

      t[0] = sub_sat(add_sat(cov[0], mul_fx(dt, cov[3])), mul_fx(h2, cov[6]));
      t[1] = sub_sat(add_sat(cov[1], mul_fx(dt, cov[4])), mul_fx(h2, cov[7]));
      t[2] = sub_sat(add_sat(cov[2], mul_fx(dt, cov[5])), mul_fx(h2, cov[8]));
      t[3] = sub_sat(cov[3], mul_fx(dt, cov[6]));
      t[4] = sub_sat(cov[4], mul_fx(dt, cov[7]));
      t[5] = sub_sat(cov[5], mul_fx(dt, cov[8]));
      t[6] = cov[6];
      t[7] = cov[7];
      t[8] = cov[8];

      cov[0] = sub_sat(add_sat(t[0], mul_fx(dt, t[1])), mul_fx(h2, t[2]));
      cov[1] = sub_sat(t[1], mul_fx(dt, t[2]));
      cov[2] = t[2];
      cov[3] = sub_sat(add_sat(t[3], mul_fx(dt, t[4])), mul_fx(h2, t[5]));
      cov[4] = sub_sat(t[4], mul_fx(dt, t[5]));
      cov[5] = t[5];
      cov[6] = sub_sat(add_sat(t[6], mul_fx(dt, t[7])), mul_fx(h2, t[8]));
      cov[7] = sub_sat(t[7], mul_fx(dt, t[8]));
      cov[8] = t[8];

      qa = longint'({32'd0, acc_var}) <<< (FRAC - 16);
      cov[0] = add_sat(cov[0], mul_fx(q4, qa));
      cov[1] = add_sat(cov[1], mul_fx(h3, qa));
      cov[3] = add_sat(cov[3], mul_fx(h3, qa));
      cov[4] = add_sat(cov[4], mul_fx(dsq, qa));
      cov[8] = add_sat(cov[8], longint'({32'd0, bias_var}) <<< (FRAC - 16));

      innov = sub_sat(a, alt_est);
      s = add_sat(cov[0], longint'({32'd0, meas_var}) <<< (FRAC - 16));
      if (s > 0) begin
        kz = div_fx(cov[0], s);
        kv = div_fx(cov[3], s);
        ka = div_fx(cov[6], s);
      end else begin
        kz = 0;
        kv = 0;
        ka = 0;
      end

      alt_est  = add_sat(alt_est, mul_fx(kz, innov));
      spd_est  = add_sat(spd_est, mul_fx(kv, innov));
      bias_est = add_sat(bias_est, mul_fx(ka, innov));

      pzz = cov[0];
      pzv = cov[1];
      pza = cov[2];
      cov[6] = sub_sat(cov[6], mul_fx(ka, pzz));
      cov[7] = sub_sat(cov[7], mul_fx(ka, pzv));
      cov[8] = sub_sat(cov[8], mul_fx(ka, pza));
      cov[3] = sub_sat(cov[3], mul_fx(kv, pzz));
      cov[4] = sub_sat(cov[4], mul_fx(kv, pzv));
      cov[5] = sub_sat(cov[5], mul_fx(kv, pza));
      cov[0] = sub_sat(cov[0], mul_fx(kz, pzz));
      cov[1] = sub_sat(cov[1], mul_fx(kz, pzv));
      cov[2] = sub_sat(cov[2], mul_fx(kz, pza));
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_MEAS: meas_var = val;
        CFG_ACC:  acc_var  = val;
        CFG_BIAS: bias_var = val;
        CFG_DMP:  damping  = val[16:0];
        default: ;
      endcase
    endfunction

    function void note_word(bit mode, logic [31:0] alt, logic [15:0] ms);
      longint      a;
      vario_word_t w;
      a = longint'(signed'(alt)) <<< (FRAC - 16);
      if (mode == MODE_INIT) begin
        restart(a);
        init_words++;
      end else begin
        filter_update(a, ms);
        update_words++;
      end
      w.alt  = to_q16(alt_est);
      w.spd  = to_q16(spd_est);
      w.bias = to_q16(bias_est);
      w.damp = to_q16(smooth);
      expected_q.push_back(w);
    endfunction

    function void check_word(logic [31:0] fa, logic [31:0] vs, logic [31:0] ab,
                             logic [31:0] da);
      vario_word_t w;
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      w = expected_q.pop_front();
      checked++;
      if (fa !== w.alt) begin
        $error("filtered_altitude expected %h actual %h", w.alt, fa);
        errors++;
      end
      if (vs !== w.spd) begin
        $error("vertical_speed expected %h actual %h", w.spd, vs);
        errors++;
      end
      if (ab !== w.bias) begin
        $error("accel_bias expected %h actual %h", w.bias, ab);
        errors++;
      end
      if (da !== w.damp) begin
        $error("damped_altitude expected %h actual %h", w.damp, da);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [31:0] in_measured_altitude;
  logic [15:0] in_elapsed_ms;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_filtered_altitude;
  logic [31:0] out_vertical_speed;
  logic [31:0] out_accel_bias;
  logic [31:0] out_damped_altitude;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  vario_scoreboard sb;
  int          hold_off;
  bit          no_idle;
  int          cycles;
  logic [31:0] track_alt;

  kalman_altitude_vario dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_measured_altitude (in_measured_altitude),
    .in_elapsed_ms        (in_elapsed_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_filtered_altitude(out_filtered_altitude),
    .out_vertical_speed   (out_vertical_speed),
    .out_accel_bias       (out_accel_bias),
    .out_damped_altitude  (out_damped_altitude),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // receiver: random stalls plus requested hold-off
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        stall = gap_len();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_word(out_filtered_altitude, out_vertical_speed, out_accel_bias,
                      out_damped_altitude);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_word(bit mode, logic [31:0] alt, logic [15:0] ms);
    int g;
    @(negedge clk);
    in_valid             = 1'b1;
    in_mode              = mode;
    in_measured_altitude = alt;
    in_elapsed_ms        = ms;
    do @(posedge clk); while (!in_ready);
    sb.note_word(mode, alt, ms);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(logic [31:0] mv, logic [31:0] av, logic [31:0] bv,
                         logic [31:0] dv);
    drain();
    write_reg(CFG_MEAS, mv);
    write_reg(CFG_ACC, av);
    write_reg(CFG_BIAS, bv);
    write_reg(CFG_DMP, dv);
  endtask

  task automatic random_words(int n);
    int r;
    logic [31:0] delta;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        track_alt = $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
        send_word(MODE_INIT, track_alt, 16'($urandom));
      end else if (r < 86) begin
        delta = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        track_alt = track_alt + delta;
        send_word(MODE_UPDATE, track_alt, 16'($urandom_range(5, 250)));
      end else begin
        send_word(1'($urandom), $urandom, 16'($urandom));
      end
    end
  endtask

  initial begin
    sb        = new();
    hold_off  = 0;
    no_idle   = 1'b0;
    track_alt = 32'd0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mode   = MODE_UPDATE;
    in_measured_altitude = 32'd0;
    in_elapsed_ms = 16'd0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MEAS;
    cfg_data  = 32'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults and directed corners
    set_all(32'd26214400, 32'd65536000, 32'd65536, 32'd3277);
    send_word(MODE_UPDATE, 32'd0, 16'd0);
    send_word(MODE_INIT, 32'd0, 16'hFFFF);
    send_word(MODE_UPDATE, 32'h7FFF_FFFF, 16'hFFFF);
    send_word(MODE_UPDATE, 32'h8000_0000, 16'd1);
    send_word(MODE_INIT, 32'h8000_0000, 16'd0);
    send_word(MODE_UPDATE, 32'h8000_0001, 16'd50);
    send_word(MODE_INIT, 32'h7FFF_FFFF, 16'd0);
    send_word(MODE_UPDATE, 32'h7FFF_FFFF, 16'hFFFF);
    send_word(MODE_UPDATE, 32'hAAAA_AAAA, 16'hAAAA);
    send_word(MODE_UPDATE, 32'h5555_5555, 16'h5555);
    send_word(MODE_INIT, 32'h0064_0000, 16'd0);
    track_alt = 32'h0064_0000;
    for (int i = 0; i < 6; i++) begin
      track_alt = track_alt + 32'h0000_8000;
      send_word(MODE_UPDATE, track_alt, 16'd50);
    end
    send_word(MODE_UPDATE, track_alt, 16'd0);
    random_words(100);

    // all registers at zero: gains collapse once pzz reaches zero
    set_all(32'd0, 32'd0, 32'd0, 32'd0);
    send_word(MODE_INIT, 32'h0010_0000, 16'd0);
    send_word(MODE_UPDATE, 32'h0011_0000, 16'd0);
    send_word(MODE_UPDATE, 32'h0012_0000, 16'd0);
    send_word(MODE_UPDATE, 32'h0013_0000, 16'd40);
    track_alt = 32'h0013_0000;
    random_words(100);

    // maxima, damping above one, long receiver hold-off
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_FFFF);
    send_word(MODE_INIT, track_alt, 16'd0);
    random_words(30);
    hold_off = 3000;
    random_words(90);

    // unity damping, no idling for a stretch, sender pause mid-phase
    set_all(32'd65536, 32'd6553600, 32'd655, 32'd65536);
    no_idle = 1'b1;
    send_word(MODE_INIT, track_alt, 16'd0);
    random_words(60);
    no_idle = 1'b0;
    drain();
    random_words(60);

    set_all($urandom, $urandom_range(0, 32'h0FFF_FFFF), $urandom_range(0, 32'h000F_FFFF),
            $urandom_range(0, 32'h0001_FFFF));
    send_word(MODE_INIT, track_alt, 16'd0);
    random_words(170);

    @(negedge clk);
    in_valid = 1'b0;
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d initialise and %0d update words over five register settings",
             sb.init_words, sb.update_words);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
